>>> design/similarity_pinhole_projection_top_macros.svh
// Assertion macros shared by the projection block.
`ifndef SIMILARITY_PINHOLE_PROJECTION_TOP_MACROS_SVH
`define SIMILARITY_PINHOLE_PROJECTION_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SPP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("projection assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SPP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("projection assertion failed");

`endif

>>> design/spp_pkg.sv
// Types, constants and register map of the pinhole projection block.
package spp_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;

   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_FACTOR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TRANSLATION  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INTR_ROW0    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INTR_ROW1    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INTR_ROW2    = 3'd7;

   localparam logic [47:0] ROT_ROW0_RST  = 48'd16384;
   localparam logic [47:0] ROT_ROW1_RST  = 48'd1073741824;
   localparam logic [47:0] ROT_ROW2_RST  = 48'd70368744177664;
   localparam logic [23:0] SCALE_RST     = 24'd65536;
   localparam logic [59:0] TRANS_RST     = 60'd0;
   localparam logic [59:0] INTR_ROW0_RST = 60'd256;
   localparam logic [59:0] INTR_ROW1_RST = 60'd268435456;
   localparam logic [59:0] INTR_ROW2_RST = 60'd281474976710656;

   localparam int CAM_W = 40;
   localparam int PIX_W = 62;
   localparam int QUO_W = 33;

   localparam logic [31:0] PIX_BEHIND = 32'hFFFF0000;
   localparam logic [31:0] PIX_MAX    = 32'h7FFFFFFF;
   localparam logic [31:0] PIX_MIN    = 32'h80000000;

   typedef struct packed {
      logic [2:0][47:0] rot;
      logic [23:0]      scale;
      logic [59:0]      trans;
      logic [2:0][59:0] intr;
   } cfg_type;

   typedef struct packed {
      logic [15:0] index;
      logic        last;
   } meta_type;

   typedef struct packed {
      logic        force_en;
      logic [31:0] force_val;
      logic        neg;
      logic        behind;
      meta_type    meta;
   } div_tag_type;

   typedef logic signed [CAM_W-1:0] cam_type;

endpackage

>>> design/spp_stream_if.sv
// Request and response channel interfaces of the projection block.
interface spp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic [15:0]        point_index;
   logic               last_point;
   modport source(output valid, point_x, point_y, point_z, point_index, last_point,
                  input ready);
   modport sink(input valid, point_x, point_y, point_z, point_index, last_point,
                output ready);
endinterface

interface spp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pixel_u;
   logic signed [31:0] pixel_v;
   logic               behind_camera;
   logic [15:0]        result_index;
   logic               result_last;
   modport source(output valid, pixel_u, pixel_v, behind_camera, result_index, result_last,
                  input ready);
   modport sink(input valid, pixel_u, pixel_v, behind_camera, result_index, result_last,
                output ready);
endinterface

>>> design/spp_transform.sv
// Rotation, scale and translation of a world point into camera space.
module spp_transform (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [31:0]       px,
   input  logic signed [31:0]       py,
   input  logic signed [31:0]       pz,
   input  spp_pkg::meta_type        meta_in,
   input  spp_pkg::cfg_type         cfg,
   output logic                     out_valid,
   output spp_pkg::cam_type         cam [3],
   output logic                     behind,
   output spp_pkg::meta_type        meta_out
);

   logic [3:0]         valid_ff;
   spp_pkg::meta_type  meta_ff [4];
   logic signed [31:0] p_arr [3];
   logic signed [47:0] prod_ff [3][3];
   logic signed [35:0] rot_ff [3];
   logic signed [35:0] rot_in [3];
   logic signed [60:0] scp_ff [3];
   logic signed [60:0] scp_in [3];
   spp_pkg::cam_type   cam_ff [3];
   spp_pkg::cam_type   cam_in [3];
   logic               behind_ff;

   assign p_arr[0] = px;
   assign p_arr[1] = py;
   assign p_arr[2] = pz;

   always_comb begin
      logic signed [49:0] acc;
      logic signed [44:0] sc;
      logic signed [45:0] sum;
      for (int r = 0; r < 3; r++) begin
         acc = 50'(prod_ff[r][0]) + 50'(prod_ff[r][1]) + 50'(prod_ff[r][2]) + 50'sd8192;
         rot_in[r] = 36'(acc >>> 14);
         scp_in[r] = 61'(rot_ff[r]) * 61'($signed({1'b0, cfg.scale}));
         sc = 45'((scp_ff[r] + 61'sd32768) >>> 16);
         sum = 46'(sc) + (46'($signed(cfg.trans[20*r +: 20])) <<< 8);
         if (sum > 46'sd549755813887) begin
            cam_in[r] = {1'b0, {(spp_pkg::CAM_W-1){1'b1}}};
         end else if (sum < -46'sd549755813888) begin
            cam_in[r] = {1'b1, {(spp_pkg::CAM_W-1){1'b0}}};
         end else begin
            cam_in[r] = 40'(sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= meta_in;
         for (int k = 1; k < 4; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[r][j] <= 48'($signed(cfg.rot[r][16*j +: 16])) * 48'(p_arr[j]);
            end
            rot_ff[r] <= rot_in[r];
            scp_ff[r] <= scp_in[r];
            cam_ff[r] <= cam_in[r];
         end
         behind_ff <= cam_in[2][spp_pkg::CAM_W-1] || (cam_in[2] == '0);
      end
   end

   assign out_valid = valid_ff[3];
   assign cam       = cam_ff;
   assign behind    = behind_ff;
   assign meta_out  = meta_ff[3];

endmodule

>>> design/spp_project.sv
// Intrinsic matrix product and preparation of the two divisions.
module spp_project (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  spp_pkg::cam_type         cam [3],
   input  logic                     behind,
   input  spp_pkg::meta_type        meta_in,
   input  spp_pkg::cfg_type         cfg,
   output logic                     out_valid,
   output logic [61:0]              num_u,
   output logic [61:0]              num_v,
   output logic [61:0]              den,
   output spp_pkg::div_tag_type     tag_u,
   output spp_pkg::div_tag_type     tag_v
);

   logic [2:0]                 valid_ff;
   spp_pkg::meta_type          meta_ff [2];
   logic                       behind_ff [2];
   logic signed [59:0]         kp_ff [3][3];
   logic signed [61:0]         pix_ff [3];
   logic signed [61:0]         pix_in [3];
   logic [61:0]                mag_in [3];
   logic [61:0]                numu_ff;
   logic [61:0]                numv_ff;
   logic [61:0]                den_ff;
   spp_pkg::div_tag_type       tagu_ff;
   spp_pkg::div_tag_type       tagv_ff;

   function automatic spp_pkg::div_tag_type build_tag(
      input logic signed [61:0] num,
      input logic signed [61:0] dv,
      input logic [61:0]        un,
      input logic [61:0]        ud,
      input logic               bhd,
      input spp_pkg::meta_type  meta
   );
      spp_pkg::div_tag_type t;
      t.meta      = meta;
      t.behind    = bhd;
      t.neg       = num[61] ^ dv[61];
      t.force_en  = 1'b0;
      t.force_val = spp_pkg::PIX_MAX;
      if (bhd) begin
         t.force_en  = 1'b1;
         t.force_val = spp_pkg::PIX_BEHIND;
      end else if (ud == '0) begin
         t.force_en  = 1'b1;
         t.force_val = (num == '0) ? '0 : (num[61] ? spp_pkg::PIX_MIN : spp_pkg::PIX_MAX);
      end else if ((un >> 16) >= ud) begin
         t.force_en  = 1'b1;
         t.force_val = t.neg ? spp_pkg::PIX_MIN : spp_pkg::PIX_MAX;
      end
      return t;
   endfunction

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         pix_in[r] = 62'(kp_ff[r][0]) + 62'(kp_ff[r][1]) + 62'(kp_ff[r][2]);
         mag_in[r] = pix_ff[r][61] ? 62'(-pix_ff[r]) : 62'(pix_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0]   <= meta_in;
         meta_ff[1]   <= meta_ff[0];
         behind_ff[0] <= behind;
         behind_ff[1] <= behind_ff[0];
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               kp_ff[r][j] <= 60'($signed(cfg.intr[r][20*j +: 20])) * 60'(cam[j]);
            end
            pix_ff[r] <= pix_in[r];
         end
         numu_ff <= mag_in[0];
         numv_ff <= mag_in[1];
         den_ff  <= mag_in[2];
         tagu_ff <= build_tag(pix_ff[0], pix_ff[2], mag_in[0], mag_in[2], behind_ff[1],
                              meta_ff[1]);
         tagv_ff <= build_tag(pix_ff[1], pix_ff[2], mag_in[1], mag_in[2], behind_ff[1],
                              meta_ff[1]);
      end
   end

   assign out_valid = valid_ff[2];
   assign num_u     = numu_ff;
   assign num_v     = numv_ff;
   assign den       = den_ff;
   assign tag_u     = tagu_ff;
   assign tag_v     = tagv_ff;

endmodule

>>> design/spp_divider.sv
// Pipelined restoring divider giving one quotient bit per stage.
module spp_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [61:0]                   num_mag,
   input  logic [61:0]                   den_mag,
   input  spp_pkg::div_tag_type          tag_in,
   output logic                          out_valid,
   output logic [spp_pkg::QUO_W-1:0]     quotient,
   output spp_pkg::div_tag_type          tag_out
);

   localparam int NS = spp_pkg::QUO_W;

   logic [NS:0]          valid_ff;
   logic [61:0]          r_ff [NS];
   logic [61:0]          d_ff [NS];
   logic [NS-1:0]        b_ff [NS];
   logic [NS-1:0]        q_ff [NS+1];
   spp_pkg::div_tag_type tag_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= {16'd0, num_mag[61:16]};
         d_ff[0]   <= den_mag;
         b_ff[0]   <= {num_mag[15:0], {(NS-16){1'b0}}};
         q_ff[0]   <= '0;
         tag_ff[0] <= tag_in;
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_stage
      logic [62:0] part;
      logic        ge;
      assign part = {r_ff[k-1], b_ff[k-1][NS-1]};
      assign ge   = part >= {1'b0, d_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k]   <= {q_ff[k-1][NS-2:0], ge};
            tag_ff[k] <= tag_ff[k-1];
         end
      end
      if (k < NS) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[k] <= ge ? 62'(part - {1'b0, d_ff[k-1]}) : 62'(part);
               d_ff[k] <= d_ff[k-1];
               b_ff[k] <= b_ff[k-1] << 1;
            end
         end
      end
   end

   assign out_valid = valid_ff[NS];
   assign quotient  = q_ff[NS];
   assign tag_out   = tag_ff[NS];

endmodule

>>> design/similarity_pinhole_projection_top.sv
// Throughput: one transaction per cycle while the response channel is not stalled;
// the 33-stage quotient pipeline sets the depth.
// A stalled response freezes every stage, so nothing is lost or repeated.
// Reset is synchronous and active high; it empties the pipeline and restores the config registers.
// Configuration writes take effect at the edge that carries them.
module similarity_pinhole_projection_top (
   input  logic                             clock,
   input  logic                             reset,
   spp_req_if.sink                          req_chan,
   spp_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_en,
   input  logic [spp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

`include "similarity_pinhole_projection_top_macros.svh"

   spp_pkg::cfg_type      cfg_ff;
   logic                  adv;
   spp_pkg::meta_type     meta_in;
   logic                  t_valid;
   spp_pkg::cam_type      t_cam [3];
   logic                  t_behind;
   spp_pkg::meta_type     t_meta;
   logic                  p_valid;
   logic [61:0]           p_num_u;
   logic [61:0]           p_num_v;
   logic [61:0]           p_den;
   spp_pkg::div_tag_type  p_tag_u;
   spp_pkg::div_tag_type  p_tag_v;
   logic                  u_valid;
   logic                  v_valid;
   logic [spp_pkg::QUO_W-1:0] u_quo;
   logic [spp_pkg::QUO_W-1:0] v_quo;
   spp_pkg::div_tag_type  u_tag;
   spp_pkg::div_tag_type  v_tag;
   logic                  rsp_valid_ff;
   logic [31:0]           rsp_u_ff;
   logic [31:0]           rsp_v_ff;
   logic                  rsp_behind_ff;
   spp_pkg::meta_type     rsp_meta_ff;

   function automatic logic [31:0] finish(input logic [spp_pkg::QUO_W-1:0] q,
                                          input spp_pkg::div_tag_type t);
      logic [spp_pkg::QUO_W:0] m;
      logic [31:0]             res;
      m = ({1'b0, q} + 34'd1) >> 1;
      if (t.force_en) begin
         res = t.force_val;
      end else if (!t.neg) begin
         res = (m > 34'h07FFFFFFF) ? spp_pkg::PIX_MAX : m[31:0];
      end else begin
         res = (m > 34'h080000000) ? spp_pkg::PIX_MIN : (~m[31:0] + 32'd1);
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot[0]  <= spp_pkg::ROT_ROW0_RST;
         cfg_ff.rot[1]  <= spp_pkg::ROT_ROW1_RST;
         cfg_ff.rot[2]  <= spp_pkg::ROT_ROW2_RST;
         cfg_ff.scale   <= spp_pkg::SCALE_RST;
         cfg_ff.trans   <= spp_pkg::TRANS_RST;
         cfg_ff.intr[0] <= spp_pkg::INTR_ROW0_RST;
         cfg_ff.intr[1] <= spp_pkg::INTR_ROW1_RST;
         cfg_ff.intr[2] <= spp_pkg::INTR_ROW2_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            spp_pkg::REG_ROT_ROW0:     cfg_ff.rot[0]  <= csr_wdata[47:0];
            spp_pkg::REG_ROT_ROW1:     cfg_ff.rot[1]  <= csr_wdata[47:0];
            spp_pkg::REG_ROT_ROW2:     cfg_ff.rot[2]  <= csr_wdata[47:0];
            spp_pkg::REG_SCALE_FACTOR: cfg_ff.scale   <= csr_wdata[23:0];
            spp_pkg::REG_TRANSLATION:  cfg_ff.trans   <= csr_wdata;
            spp_pkg::REG_INTR_ROW0:    cfg_ff.intr[0] <= csr_wdata;
            spp_pkg::REG_INTR_ROW1:    cfg_ff.intr[1] <= csr_wdata;
            spp_pkg::REG_INTR_ROW2:    cfg_ff.intr[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign meta_in.index  = req_chan.point_index;
   assign meta_in.last   = req_chan.last_point;

   spp_transform u_transform (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_chan.valid),
      .px        (req_chan.point_x),
      .py        (req_chan.point_y),
      .pz        (req_chan.point_z),
      .meta_in   (meta_in),
      .cfg       (cfg_ff),
      .out_valid (t_valid),
      .cam       (t_cam),
      .behind    (t_behind),
      .meta_out  (t_meta)
   );

   spp_project u_project (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (t_valid),
      .cam       (t_cam),
      .behind    (t_behind),
      .meta_in   (t_meta),
      .cfg       (cfg_ff),
      .out_valid (p_valid),
      .num_u     (p_num_u),
      .num_v     (p_num_v),
      .den       (p_den),
      .tag_u     (p_tag_u),
      .tag_v     (p_tag_v)
   );

   spp_divider u_div_u (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p_valid),
      .num_mag   (p_num_u),
      .den_mag   (p_den),
      .tag_in    (p_tag_u),
      .out_valid (u_valid),
      .quotient  (u_quo),
      .tag_out   (u_tag)
   );

   spp_divider u_div_v (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p_valid),
      .num_mag   (p_num_v),
      .den_mag   (p_den),
      .tag_in    (p_tag_v),
      .out_valid (v_valid),
      .quotient  (v_quo),
      .tag_out   (v_tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= u_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_u_ff      <= finish(u_quo, u_tag);
         rsp_v_ff      <= finish(v_quo, v_tag);
         rsp_behind_ff <= u_tag.behind;
         rsp_meta_ff   <= u_tag.meta;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pixel_u       = rsp_u_ff;
   assign rsp_chan.pixel_v       = rsp_v_ff;
   assign rsp_chan.behind_camera = rsp_behind_ff;
   assign rsp_chan.result_index  = rsp_meta_ff.index;
   assign rsp_chan.result_last   = rsp_meta_ff.last;

   `SPP_ASSERT_IMP(a_div_lockstep, 1'b1, u_valid == v_valid)
   `SPP_ASSERT_IMP(a_tag_match, u_valid, u_tag.meta == v_tag.meta && u_tag.behind == v_tag.behind)
   `SPP_ASSERT_IMP(a_behind_pixel, rsp_valid_ff && rsp_behind_ff, rsp_u_ff == spp_pkg::PIX_BEHIND && rsp_v_ff == spp_pkg::PIX_BEHIND)
   `SPP_ASSERT_NXT(a_stall_hold, !adv, $stable(u_quo) && $stable(u_valid))

endmodule

>>> tb/tb_similarity_pinhole_projection_top.sv
// Self-checking testbench of the pinhole projection block with randomized stimulus and stalls.
`timescale 1ns / 100ps

module tb_similarity_pinhole_projection_top;

   typedef struct {
      logic [31:0] u;
      logic [31:0] v;
      logic        behind;
      logic [15:0] index;
      logic        last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_write_en = 1'b0;
   logic [spp_pkg::CSR_IDX_W-1:0]  csr_index = spp_pkg::REG_ROT_ROW0;
   logic [spp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   spp_req_if req_chan ();
   spp_rsp_if rsp_chan ();

   similarity_pinhole_projection_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   logic [47:0] rot_cfg [3];
   logic [23:0] scale_cfg;
   logic [59:0] trans_cfg;
   logic [59:0] intr_cfg [3];

   pixel_type pending_pixels [$];
   int        error_count = 0;
   bit        burst_mode = 0;
   int        rsp_hold_cycles = 0;

   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("FAIL similarity_pinhole_projection_top");
      $finish;
   end

   function automatic longint rounded_shift(longint x, int n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic logic [31:0] divide_q16(longint num, longint den);
      bit                neg;
      longint unsigned   un, ud, q, r, mag;
      neg = (num < 0) != (den < 0);
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      if (ud == 0) begin
         return num > 0 ? spp_pkg::PIX_MAX : (num < 0 ? spp_pkg::PIX_MIN : 32'd0);
      end
      q = un / ud;
      r = un % ud;
      if (q > 65536) begin
         return neg ? spp_pkg::PIX_MIN : spp_pkg::PIX_MAX;
      end
      for (int i = 0; i < 17; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= ud) begin
            r = r - ud;
            q = q | 1;
         end
      end
      mag = (q + 1) >> 1;
      if (!neg) begin
         return mag > 64'h7FFFFFFF ? spp_pkg::PIX_MAX : mag[31:0];
      end
      return mag > 64'h80000000 ? spp_pkg::PIX_MIN : 32'(-mag);
   endfunction

   function automatic pixel_type project_point(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz, logic [15:0] idx,
                                               logic lst);
      pixel_type res;
      longint    p [3];
      longint    cam [3];
      longint    pix [3];
      longint    acc, elem, rot, sc, tr, s;
      p[0] = $signed(px);
      p[1] = $signed(py);
      p[2] = $signed(pz);
      s = scale_cfg;
      for (int r = 0; r < 3; r++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            elem = $signed(rot_cfg[r][16*j +: 16]);
            acc += elem * p[j];
         end
         rot = rounded_shift(acc, 14);
         sc = rounded_shift(rot * s, 16);
         elem = $signed(trans_cfg[20*r +: 20]);
         tr = elem * 256;
         cam[r] = sc + tr;
         if (cam[r] > 64'sd549755813887) cam[r] = 64'sd549755813887;
         if (cam[r] < -64'sd549755813888) cam[r] = -64'sd549755813888;
      end
      res.index = idx;
      res.last = lst;
      if (cam[2] <= 0) begin
         res.u = spp_pkg::PIX_BEHIND;
         res.v = spp_pkg::PIX_BEHIND;
         res.behind = 1'b1;
      end else begin
         for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
               elem = $signed(intr_cfg[r][20*j +: 20]);
               acc += elem * cam[j];
            end
            pix[r] = acc;
         end
         res.u = divide_q16(pix[0], pix[2]);
         res.v = divide_q16(pix[1], pix[2]);
         res.behind = 1'b0;
      end
      return res;
   endfunction

   task automatic write_csr(logic [spp_pkg::CSR_IDX_W-1:0] idx,
                            logic [spp_pkg::CSR_DATA_W-1:0] value);
      req_chan.valid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (45) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         spp_pkg::REG_ROT_ROW0:     rot_cfg[0] = value[47:0];
         spp_pkg::REG_ROT_ROW1:     rot_cfg[1] = value[47:0];
         spp_pkg::REG_ROT_ROW2:     rot_cfg[2] = value[47:0];
         spp_pkg::REG_SCALE_FACTOR: scale_cfg = value[23:0];
         spp_pkg::REG_TRANSLATION:  trans_cfg = value[59:0];
         spp_pkg::REG_INTR_ROW0:    intr_cfg[0] = value[59:0];
         spp_pkg::REG_INTR_ROW1:    intr_cfg[1] = value[59:0];
         spp_pkg::REG_INTR_ROW2:    intr_cfg[2] = value[59:0];
         default: ;
      endcase
   endtask

   task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [15:0] idx, logic lst);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.point_x <= px;
      req_chan.point_y <= py;
      req_chan.point_z <= pz;
      req_chan.point_index <= idx;
      req_chan.last_point <= lst;
      do @(posedge clock); while (!req_chan.ready);
      pending_pixels.push_back(project_point(px, py, pz, idx, lst));
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 3))
         0:       return $urandom();
         1:       return $urandom_range(0, 32'h00FFFFFF);
         default: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
      endcase
   endfunction

   function automatic logic [15:0] small_q14();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic logic [19:0] random_q8(int span);
      return 20'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic load_random_pose(bit wild);
      for (int r = 0; r < 3; r++) begin
         if (wild) begin
            write_csr(spp_pkg::CSR_IDX_W'(spp_pkg::REG_ROT_ROW0 + r),
                      60'({$urandom(), $urandom()}));
         end else begin
            write_csr(spp_pkg::CSR_IDX_W'(spp_pkg::REG_ROT_ROW0 + r),
                      60'({small_q14(), small_q14(), small_q14()}));
         end
      end
      write_csr(spp_pkg::REG_SCALE_FACTOR,
                60'(wild ? $urandom() : $urandom_range(16384, 262144)));
      write_csr(spp_pkg::REG_TRANSLATION, wild ? 60'({$urandom(), $urandom()}) :
                {random_q8(65536), random_q8(65536), random_q8(65536)});
      write_csr(spp_pkg::REG_INTR_ROW0, wild ? 60'({$urandom(), $urandom()}) :
                {random_q8(200000), 20'd0, 20'($urandom_range(256, 250000))});
      write_csr(spp_pkg::REG_INTR_ROW1, wild ? 60'({$urandom(), $urandom()}) :
                {random_q8(200000), 20'($urandom_range(256, 250000)), 20'd0});
      write_csr(spp_pkg::REG_INTR_ROW2, wild ? 60'({$urandom(), $urandom()}) :
                {20'($urandom_range(1, 1024)), random_q8(16), random_q8(16)});
   endtask

   task automatic test_reset_defaults();
      send_point(32'h0, 32'h0, 32'h0, 16'h0000, 1'b0);
      send_point(32'h00010000, 32'h00020000, 32'h00010000, 16'hFFFF, 1'b1);
      send_point(32'h7FFFFFFF, 32'h80000000, 32'h00000001, 16'h5555, 1'b0);
      send_point(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hAAAA, 1'b1);
      send_point(32'h00010000, 32'h00010000, 32'hFFFF0000, 16'h0001, 1'b0);
      send_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 16'h0002, 1'b1);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000001, 16'h0003, 1'b0);
   endtask

   task automatic test_extreme_configs();
      write_csr(spp_pkg::REG_SCALE_FACTOR, 60'(24'hFFFFFF));
      write_csr(spp_pkg::REG_TRANSLATION, {20'h7FFFF, 20'h80000, 20'h7FFFF});
      send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h0010, 1'b0);
      send_point(32'h0, 32'h0, 32'h80000000, 16'h0011, 1'b1);
      write_csr(spp_pkg::REG_ROT_ROW0, 60'({16'h8000, 16'h7FFF, 16'h8000}));
      write_csr(spp_pkg::REG_ROT_ROW1, 60'({16'h7FFF, 16'h8000, 16'h7FFF}));
      write_csr(spp_pkg::REG_ROT_ROW2, 60'({16'h8000, 16'h8000, 16'h8000}));
      send_point(32'h80000000, 32'h80000000, 32'h80000000, 16'h0012, 1'b0);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0013, 1'b1);
      write_csr(spp_pkg::REG_SCALE_FACTOR, 60'(24'h0));
      send_point(32'h12345678, 32'h9ABCDEF0, 32'h0FEDCBA9, 16'h0014, 1'b0);
      write_csr(spp_pkg::REG_INTR_ROW0, {20'h7FFFF, 20'h80000, 20'h7FFFF});
      write_csr(spp_pkg::REG_INTR_ROW1, {20'h80000, 20'h7FFFF, 20'h80000});
      write_csr(spp_pkg::REG_INTR_ROW2, 60'h0);
      send_point(32'h0, 32'h0, 32'h0, 16'h0015, 1'b0);
      write_csr(spp_pkg::REG_SCALE_FACTOR, 60'(24'h010000));
      write_csr(spp_pkg::REG_TRANSLATION, {20'h00100, 20'h0, 20'h0});
      send_point(32'h00010000, 32'hFFFF0000, 32'h0, 16'h0016, 1'b1);
      send_point(32'h0, 32'h0, 32'h0, 16'h0017, 1'b0);
      write_csr(spp_pkg::REG_INTR_ROW2, {20'h00001, 20'h0, 20'h0});
      send_point(32'h7FFFFFFF, 32'h80000000, 32'h0, 16'h0018, 1'b1);
      send_point(32'h00000001, 32'hFFFFFFFF, 32'h0, 16'h0019, 1'b0);
      write_csr(spp_pkg::REG_ROT_ROW0, 60'(spp_pkg::ROT_ROW0_RST));
      write_csr(spp_pkg::REG_ROT_ROW1, 60'(spp_pkg::ROT_ROW1_RST));
      write_csr(spp_pkg::REG_ROT_ROW2, 60'(spp_pkg::ROT_ROW2_RST));
      write_csr(spp_pkg::REG_TRANSLATION, spp_pkg::TRANS_RST);
      write_csr(spp_pkg::REG_INTR_ROW0, spp_pkg::INTR_ROW0_RST);
      write_csr(spp_pkg::REG_INTR_ROW1, spp_pkg::INTR_ROW1_RST);
      write_csr(spp_pkg::REG_INTR_ROW2, spp_pkg::INTR_ROW2_RST);
   endtask

   task automatic test_random_batches();
      logic [31:0] pz;
      for (int phase = 0; phase < 8; phase++) begin
         load_random_pose(phase == 3 || phase == 6);
         burst_mode = (phase % 3 == 1);
         for (int n = 0; n < 150; n++) begin
            pz = ($urandom_range(0, 4) == 0) ? random_coord() :
                 $urandom_range(32'h00010000, 32'h0FFFFFFF);
            send_point(random_coord(), random_coord(), pz, 16'(n), n == 149);
         end
      end
      burst_mode = 0;
   endtask

   task automatic test_backpressure();
      req_chan.valid <= 1'b0;
      wait (pending_pixels.size() == 0);
      rsp_hold_cycles = 300;
      burst_mode = 1;
      for (int n = 0; n < 150; n++) begin
         send_point($urandom(), $urandom(), $urandom_range(1, 32'h7FFFFFFF),
                    16'($urandom()), 1'($urandom_range(0, 1)));
      end
      burst_mode = 0;
   endtask

   initial begin
      forever begin
         int stall;
         stall = burst_mode ? 0 : $urandom_range(0, 8);
         if (rsp_hold_cycles > 0) begin
            stall = stall + rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            $error("unexpected transaction on response channel");
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_chan.pixel_u !== want.u) begin
               $error("pixel_u expected %h got %h", want.u, rsp_chan.pixel_u);
               error_count++;
            end
            if (rsp_chan.pixel_v !== want.v) begin
               $error("pixel_v expected %h got %h", want.v, rsp_chan.pixel_v);
               error_count++;
            end
            if (rsp_chan.behind_camera !== want.behind) begin
               $error("behind_camera expected %b got %b", want.behind,
                      rsp_chan.behind_camera);
               error_count++;
            end
            if (rsp_chan.result_index !== want.index) begin
               $error("result_index expected %h got %h", want.index,
                      rsp_chan.result_index);
               error_count++;
            end
            if (rsp_chan.result_last !== want.last) begin
               $error("result_last expected %b got %b", want.last, rsp_chan.result_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      rot_cfg[0] = spp_pkg::ROT_ROW0_RST;
      rot_cfg[1] = spp_pkg::ROT_ROW1_RST;
      rot_cfg[2] = spp_pkg::ROT_ROW2_RST;
      scale_cfg = spp_pkg::SCALE_RST;
      trans_cfg = spp_pkg::TRANS_RST;
      intr_cfg[0] = spp_pkg::INTR_ROW0_RST;
      intr_cfg[1] = spp_pkg::INTR_ROW1_RST;
      intr_cfg[2] = spp_pkg::INTR_ROW2_RST;
      req_chan.valid <= 1'b0;
      req_chan.point_x <= '0;
      req_chan.point_y <= '0;
      req_chan.point_z <= '0;
      req_chan.point_index <= '0;
      req_chan.last_point <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extreme_configs();
      test_random_batches();
      test_backpressure();
      req_chan.valid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && pending_pixels.size() == 0) begin
         $display("PASS similarity_pinhole_projection_top");
      end else begin
         $display("FAIL similarity_pinhole_projection_top");
      end
      $finish;
   end

endmodule
